@@ rtl/i64dt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i64dt_pkg: shared types and constants for the decimal text converter
// Widths of the binary and bcd words, ascii codes, sequencer states and the
// mode select of the shared shift unit.
// ----------------------------------------------------------------------------
package i64dt_pkg;

    localparam int BIN_W      = 64;
    localparam int NUM_DIGITS = 20;
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int CNT_W      = $clog2(BIN_W);
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_EMIT
    } state_t;

    typedef enum logic {
        SHIFT_DABBLE,
        SHIFT_DIGIT
    } shift_mode_t;

endpackage

@@ rtl/i64dt_shift_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i64dt_shift_unit: shared bcd shift unit
// One double-dabble step (add 3 to every digit of 5 or more, then shift in
// one binary bit), or a shift left by one whole digit.
// ----------------------------------------------------------------------------
module i64dt_shift_unit (
    input  i64dt_pkg::shift_mode_t         mode,
    input  logic                           bit_in,
    input  logic [i64dt_pkg::BCD_W-1:0]    bcd_in,
    output logic [i64dt_pkg::BCD_W-1:0]    bcd_out
);
    import i64dt_pkg::*;

    logic [BCD_W-1:0] adjusted;

    // digits are independent, so this loop is parallel logic
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_in[4*i +: 4] >= 4'd5)
                adjusted[4*i +: 4] = bcd_in[4*i +: 4] + 4'd3;
            else
                adjusted[4*i +: 4] = bcd_in[4*i +: 4];
        end
    end

    always_comb
    begin
        unique case (mode)
            SHIFT_DABBLE: bcd_out = {adjusted[BCD_W-2:0], bit_in};
            SHIFT_DIGIT:  bcd_out = {bcd_in[BCD_W-5:0], 4'd0};
            default:      bcd_out = bcd_in;
        endcase
    end

endmodule

@@ rtl/int64_to_decimal_text_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int64_to_decimal_text_core: signed 64-bit integer to decimal ascii text
// Converts the magnitude to bcd by double dabble, drops leading zeros and
// sends a minus sign (if negative) and the digits, most significant first.
// ----------------------------------------------------------------------------
//
//  channel  signals                         direction  item
//  -------  ------------------------------  ---------  ------------------------
//  input    in_valid, in_stall, value       in         one signed 64-bit number
//  output   out_valid, out_stall,           out        one ascii character,
//           char_code, last                            last on the final one
//
// an item is accepted, then converted by double dabble on the shared shift
// unit, one step per magnitude bit; then its leading zero digits are dropped
// and the characters are sent, the minus sign first; dropped zeros and digits
// always make 20.
// reset clears the sequencer only; no clearing pass is needed.
// in_stall is high from accept until the last character is taken; out_stall
// simply holds the current character.
module int64_to_decimal_text_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [63:0]             value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     char_code,
    output logic                           last
);
    import i64dt_pkg::*;

    localparam logic [CNT_W-1:0]  LAST_BIT   = CNT_W'(BIN_W - 1);
    localparam logic [LEFT_W-1:0] ALL_DIGITS = LEFT_W'(NUM_DIGITS);
    localparam logic [LEFT_W-1:0] ONE_LEFT   = LEFT_W'(1);

    state_t            state_reg, state_next;
    logic [BIN_W-1:0]  mag_reg, mag_next;         // magnitude, shifted out msb first
    logic [BCD_W-1:0]  bcd_reg, bcd_next;         // bcd digits, leading digit on top
    logic [CNT_W-1:0]  cnt_reg, cnt_next;         // dabble step count
    logic [LEFT_W-1:0] left_reg, left_next;       // digits still to send or drop
    logic              sign_reg, sign_next;       // minus sign still to send

    shift_mode_t       unit_mode;
    logic [BCD_W-1:0]  unit_out;
    logic [3:0]        top_digit;

    i64dt_shift_unit u_shift (
        .mode    (unit_mode),
        .bit_in  (mag_reg[BIN_W-1]),
        .bcd_in  (bcd_reg),
        .bcd_out (unit_out)
    );

    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    // outputs come straight from registers, so they hold under stall
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign char_code = sign_reg ? CHAR_MINUS : (CHAR_ZERO + {4'd0, top_digit});
    assign last      = !sign_reg && (left_reg == ONE_LEFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sign_reg  <= 1'b0;
            cnt_reg   <= '0;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sign_reg  <= sign_next;
            cnt_reg   <= cnt_next;
            left_reg  <= left_next;
        end
    end

    // datapath registers need no reset
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        left_next  = left_reg;
        sign_next  = sign_reg;
        unit_mode  = SHIFT_DIGIT;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    // two's complement negate also covers the most negative value
                    sign_next  = value[BIN_W-1];
                    mag_next   = value[BIN_W-1] ? (~value + 64'd1) : value;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_CONVERT;
                end
            end

            ST_CONVERT:
            begin
                unit_mode = SHIFT_DABBLE;
                bcd_next  = unit_out;
                mag_next  = {mag_reg[BIN_W-2:0], 1'b0};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_BIT)
                begin
                    left_next  = ALL_DIGITS;
                    state_next = ST_SKIP;
                end
            end

            ST_SKIP:
            begin
                // drop leading zeros, keeping at least one digit for zero
                if (top_digit == 4'd0 && left_reg != ONE_LEFT)
                begin
                    bcd_next  = unit_out;
                    left_next = left_reg - ONE_LEFT;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    if (sign_reg)
                    begin
                        sign_next = 1'b0;
                    end
                    else
                    begin
                        bcd_next  = unit_out;
                        left_next = left_reg - ONE_LEFT;
                        if (left_reg == ONE_LEFT)
                            state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
